>>> rtl/pwft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwft_pkg
// Types, constants and helpers shared by the pulse width frame transmitter.
// ----------------------------------------------------------------------------
package pwft_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  localparam logic [7:0] SYNC_WORD_BYTE = 8'h55;
  localparam logic [7:0] TAIL_WORD_BYTE = 8'h77;

  localparam logic [15:0] RST_HIGH_TIME      = 16'd80;
  localparam logic [15:0] RST_ZERO_LOW_TIME  = 16'd100;
  localparam logic [15:0] RST_ONE_EXTRA_TIME = 16'd50;
  localparam logic [15:0] RST_SYNC_GAP       = 16'd10;
  localparam logic [15:0] RST_END_GAP        = 16'd100;
  localparam logic [7:0]  RST_NODE_ID        = 8'h01;
  localparam logic [4:0]  RST_PREAMBLE_BITS  = 5'd14;

  typedef enum logic [2:0] {
    REG_HIGH_TIME      = 3'd0,
    REG_ZERO_LOW_TIME  = 3'd1,
    REG_ONE_EXTRA_TIME = 3'd2,
    REG_SYNC_GAP       = 3'd3,
    REG_END_GAP        = 3'd4,
    REG_NODE_ID        = 3'd5,
    REG_PREAMBLE_BITS  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_SYNC  = 3'd2,
    PH_SGAP  = 3'd3,
    PH_BYTES = 3'd4,
    PH_STOP  = 3'd5,
    PH_EGAP  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    PT_HIGH = 2'd0,
    PT_LOW  = 2'd1,
    PT_GAP  = 2'd2
  } part_e;

  typedef struct packed {
    logic [15:0] high_time;
    logic [15:0] zero_low_time;
    logic [15:0] one_extra_time;
    logic [15:0] sync_gap;
    logic [15:0] end_gap;
    logic [7:0]  node_id;
    logic [4:0]  preamble_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic [7:0] frame_length;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [PAYLOAD_AW-1:0] waddr;
    logic [7:0]            wdata;
    logic [PAYLOAD_AW-1:0] raddr;
  } store_req_t;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    at_least_one = (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pwft_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwft_regs
// Configuration register file with its bus write and read decode.
// ----------------------------------------------------------------------------
module pwft_regs import pwft_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[CFG_AW-1:2];
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_HIGH_TIME:      cfg_nxt.high_time      = pwdata[15:0];
        REG_ZERO_LOW_TIME:  cfg_nxt.zero_low_time  = pwdata[15:0];
        REG_ONE_EXTRA_TIME: cfg_nxt.one_extra_time = pwdata[15:0];
        REG_SYNC_GAP:       cfg_nxt.sync_gap       = pwdata[15:0];
        REG_END_GAP:        cfg_nxt.end_gap        = pwdata[15:0];
        REG_NODE_ID:        cfg_nxt.node_id        = pwdata[7:0];
        REG_PREAMBLE_BITS:  cfg_nxt.preamble_bits  = pwdata[4:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HIGH_TIME:      prdata = {16'd0, cfg_r.high_time};
      REG_ZERO_LOW_TIME:  prdata = {16'd0, cfg_r.zero_low_time};
      REG_ONE_EXTRA_TIME: prdata = {16'd0, cfg_r.one_extra_time};
      REG_SYNC_GAP:       prdata = {16'd0, cfg_r.sync_gap};
      REG_END_GAP:        prdata = {16'd0, cfg_r.end_gap};
      REG_NODE_ID:        prdata = {24'd0, cfg_r.node_id};
      REG_PREAMBLE_BITS:  prdata = {27'd0, cfg_r.preamble_bits};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_time      <= RST_HIGH_TIME;
      cfg_r.zero_low_time  <= RST_ZERO_LOW_TIME;
      cfg_r.one_extra_time <= RST_ONE_EXTRA_TIME;
      cfg_r.sync_gap       <= RST_SYNC_GAP;
      cfg_r.end_gap        <= RST_END_GAP;
      cfg_r.node_id        <= RST_NODE_ID;
      cfg_r.preamble_bits  <= RST_PREAMBLE_BITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pwft_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwft_store
// Payload byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pwft_store import pwft_pkg::*; (
  input  wire logic       clk,
  input  wire store_req_t req,
  output logic      [7:0] rd_data
);

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pwft_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwft_core
// Frame sequencer: advances the waveform state by one item per fire.
// ----------------------------------------------------------------------------
module pwft_core import pwft_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire item_t      item,
  input  wire cfg_t       cfg,
  input  wire logic [7:0] rd_data,
  output store_req_t      store_req,
  output res_t            res
);

  phase_e      phase_r, phase_nxt;
  part_e       part_r, part_nxt;
  logic [4:0]  uc_r, uc_nxt;
  logic [8:0]  bc_r, bc_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [16:0] tl_r, tl_nxt;
  logic [7:0]  len_r, len_nxt;

  logic        busy;
  logic        cur_bit;
  logic        done;
  logic [16:0] tl_dec;
  logic [16:0] high1;
  logic [16:0] low_time;
  logic [4:0]  uc_inc;
  logic [8:0]  bc_inc;
  logic [7:0]  load_val;

  assign busy    = (phase_r != PH_IDLE);
  assign cur_bit = (phase_r == PH_SYNC) || ((phase_r == PH_BYTES) && shift_r[7]);
  assign tl_dec  = (tl_r != 17'd0) ? tl_r - 17'd1 : 17'd0;
  assign high1   = {1'b0, at_least_one(cfg.high_time)};
  assign low_time = {1'b0, at_least_one(cfg.zero_low_time)} +
                    (cur_bit ? {1'b0, cfg.one_extra_time} : 17'd0);
  assign uc_inc  = uc_r + 5'd1;
  assign bc_inc  = bc_r + 9'd1;

  // The read port is aimed at the payload byte that the next load needs.
  assign store_req.raddr = bc_r[PAYLOAD_AW-1:0] - PAYLOAD_AW'(3);
  assign store_req.we    = fire && !busy && (item.operation == OP_WRITE) &&
                           ({1'b0, item.byte_index} < 9'(PAYLOAD_DEPTH));
  assign store_req.waddr = item.byte_index[PAYLOAD_AW-1:0];
  assign store_req.wdata = item.byte_value;

  always_comb begin
    case (bc_inc)
      9'd1:    load_val = cfg.node_id;
      9'd2:    load_val = len_r;
      9'd3:    load_val = TAIL_WORD_BYTE;
      default: load_val = rd_data;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    part_nxt  = part_r;
    uc_nxt    = uc_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    tl_nxt    = tl_r;
    len_nxt   = len_r;
    done      = 1'b0;
    res       = '0;
    if (fire) begin
      case (item.operation)
        OP_TICK: begin
          if (busy) begin
            res.line_level = (part_r == PT_HIGH);
            res.busy_res   = 1'b1;
            tl_nxt         = tl_dec;
            if (tl_dec == 17'd0) begin
              case (part_r)
                PT_HIGH: begin
                  part_nxt = PT_LOW;
                  tl_nxt   = low_time;
                end
                PT_LOW: begin
                  case (phase_r)
                    PH_PRE: begin
                      uc_nxt   = uc_inc;
                      part_nxt = PT_HIGH;
                      tl_nxt   = high1;
                      if (uc_inc >= cfg.preamble_bits) begin
                        phase_nxt = PH_SYNC;
                        uc_nxt    = 5'd0;
                      end
                    end
                    PH_SYNC: begin
                      if (cfg.sync_gap != 16'd0) begin
                        phase_nxt = PH_SGAP;
                        part_nxt  = PT_GAP;
                        tl_nxt    = {1'b0, cfg.sync_gap};
                      end else begin
                        phase_nxt = PH_BYTES;
                        bc_nxt    = 9'd0;
                        shift_nxt = SYNC_WORD_BYTE;
                        uc_nxt    = 5'd0;
                        part_nxt  = PT_HIGH;
                        tl_nxt    = high1;
                      end
                    end
                    PH_BYTES: begin
                      shift_nxt = {shift_r[6:0], 1'b0};
                      uc_nxt    = uc_inc;
                      part_nxt  = PT_HIGH;
                      tl_nxt    = high1;
                      if (uc_inc >= 5'd8) begin
                        bc_nxt = bc_inc;
                        uc_nxt = 5'd0;
                        if (bc_inc >= 9'd4 + {1'b0, len_r}) begin
                          phase_nxt = PH_STOP;
                        end else begin
                          shift_nxt = load_val;
                        end
                      end
                    end
                    PH_STOP: begin
                      uc_nxt = uc_inc;
                      if (uc_inc < 5'd2) begin
                        part_nxt = PT_HIGH;
                        tl_nxt   = high1;
                      end else if (cfg.end_gap != 16'd0) begin
                        phase_nxt = PH_EGAP;
                        part_nxt  = PT_GAP;
                        tl_nxt    = {1'b0, cfg.end_gap};
                      end else begin
                        done = 1'b1;
                      end
                    end
                    default: done = 1'b1;
                  endcase
                end
                default: begin
                  if (phase_r == PH_SGAP) begin
                    phase_nxt = PH_BYTES;
                    bc_nxt    = 9'd0;
                    shift_nxt = SYNC_WORD_BYTE;
                    uc_nxt    = 5'd0;
                    part_nxt  = PT_HIGH;
                    tl_nxt    = high1;
                  end else begin
                    done = 1'b1;
                  end
                end
              endcase
            end
            if (done) begin
              res.frame_done = 1'b1;
              phase_nxt      = PH_IDLE;
              part_nxt       = PT_HIGH;
              uc_nxt         = 5'd0;
              bc_nxt         = 9'd0;
              tl_nxt         = 17'd0;
            end
          end
        end
        OP_WRITE, OP_START: begin
          if (busy) begin
            res.rejected = 1'b1;
          end else if (item.operation == OP_START) begin
            len_nxt  = item.frame_length;
            bc_nxt   = 9'd0;
            uc_nxt   = 5'd0;
            part_nxt = PT_HIGH;
            tl_nxt   = high1;
            if (cfg.preamble_bits != 5'd0) begin
              phase_nxt = PH_PRE;
            end else begin
              phase_nxt = PH_SYNC;
            end
          end
          res.busy_res = (phase_nxt != PH_IDLE);
        end
        default: res.busy_res = busy;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      part_r  <= PT_HIGH;
      uc_r    <= '0;
      bc_r    <= '0;
      shift_r <= '0;
      tl_r    <= '0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      uc_r    <= uc_nxt;
      bc_r    <= bc_nxt;
      shift_r <= shift_nxt;
      tl_r    <= tl_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pwft_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwft_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module pwft_out_buf import pwft_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_res,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic out_v_r, out_v_nxt;
  logic sk_v_r, sk_v_nxt;
  res_t out_d_r, out_d_nxt;
  res_t sk_d_r, sk_d_nxt;
  logic pop;

  assign pop       = out_v_r && out_ready;
  assign space     = !sk_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    out_d_nxt = out_d_r;
    sk_d_nxt  = sk_d_r;
    if (push) begin
      if (!out_v_r || pop) begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_res;
      end else begin
        sk_v_nxt = 1'b1;
        sk_d_nxt = push_res;
      end
    end else if (pop) begin
      if (sk_v_r) begin
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/pulse_width_frame_transmitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_frame_transmitter
// Pulse width on-off-keyed radio frame transmitter, one tick per request.
//
// Channel  Direction  Content
// in_      slave      tuser: operation; tdata: byte_index, byte_value, frame_length
// out_     master     tdata: line_level, busy_res, rejected; tlast: frame_done
// cfg_     slave      bus registers at byte address 4*i, seven registers
//
// One request is accepted per cycle while the output buffer has space; the
// sequencer step after the input register sets that rate. Reset is
// synchronous and clears the frame state and the registers; the payload
// memory holds whatever was written before. A stalled result sits in a
// two-entry buffer, and input is refused only once both entries are full.
// ----------------------------------------------------------------------------
module pulse_width_frame_transmitter import pwft_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [7:0] byte_index, [15:8] byte_value, [23:16] frame_length
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] line_level, [1] busy_res, [2] rejected, [7:3] zero
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  output logic      [CFG_DW-1:0]     cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t       cfg;
  item_t      item_r, item_nxt;
  logic       in_v_r, in_v_nxt;
  logic       space;
  logic       fire;
  logic [7:0] rd_data;
  store_req_t store_req;
  res_t       res;
  res_t       out_res;

  assign cfg_pready = 1'b1;
  assign fire       = in_v_r && space;
  assign in_tready  = !in_v_r || fire;

  always_comb begin
    in_v_nxt = in_v_r;
    item_nxt = item_r;
    if (in_tready) begin
      in_v_nxt              = in_tvalid;
      item_nxt.operation    = in_tuser;
      item_nxt.byte_index   = in_tdata[7:0];
      item_nxt.byte_value   = in_tdata[15:8];
      item_nxt.frame_length = in_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  pwft_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  pwft_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  pwft_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .cfg       (cfg),
    .rd_data   (rd_data),
    .store_req (store_req),
    .res       (res)
  );

  pwft_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_res  (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.rejected, out_res.busy_res, out_res.line_level};
  assign out_tlast = out_res.frame_done;

endmodule
`default_nettype wire

>>> rtl/pwft_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwft_checker
// Port-level checks of the transmitter's result stream.
// ----------------------------------------------------------------------------
module pwft_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1] && !out_tdata[2])
    else $error("frame end reported outside a frame");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && !out_tdata[0])
    else $error("rejected request shows line activity or no frame");

  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("line driven high while idle");

endmodule

bind pulse_width_frame_transmitter pwft_checker u_pwft_checker (.*);
`default_nettype wire
